[rtl/pcs_pkg.sv]
`default_nettype none

package pcs_pkg;

  localparam int TERMS        = 32;
  localparam int TOP_EXPONENT = 31;
  localparam int TOP_INDEX    = (TOP_EXPONENT < TERMS - 1) ? TOP_EXPONENT : TERMS - 1;
  localparam int IDX_W        = $clog2(TERMS);
  localparam int ACT_W        = 3;
  localparam int EXP_W        = 8;
  localparam int DATA_W       = 32;
  localparam int DEG_W        = 5;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int RND_W        = PROD_W - 16;
  localparam int SUM_W        = RND_W + 1;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_ASSIGN = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_READ   = 3'd3,
    ACT_EVAL   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic mul_en;
    logic acc_en;
  } horner_ctrl_t;

endpackage

`default_nettype wire

[rtl/pcs_cell.sv]
`default_nettype none

module pcs_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             shift_i,
  input  wire logic signed [pcs_pkg::DATA_W-1:0] data_i,
  output logic signed [pcs_pkg::DATA_W-1:0]      data_o
);

  logic signed [pcs_pkg::DATA_W-1:0] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (shift_i) begin
      coef_q <= data_i;
    end
  end

  assign data_o = coef_q;

endmodule

`default_nettype wire

[rtl/pcs_horner.sv]
`default_nettype none

module pcs_horner (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pcs_pkg::horner_ctrl_t            ctrl_i,
  input  wire logic signed [pcs_pkg::DATA_W-1:0] x_i,
  input  wire logic signed [pcs_pkg::DATA_W-1:0] coef_i,
  output logic signed [pcs_pkg::DATA_W-1:0]      acc_o,
  output logic                                  sat_o
);

  logic signed [pcs_pkg::PROD_W-1:0] prod_q;
  logic signed [pcs_pkg::DATA_W-1:0] acc_q, acc_d;
  logic                              sat_q, clip;
  logic signed [pcs_pkg::PROD_W-1:0] biased;
  logic signed [pcs_pkg::RND_W-1:0]  rnd;
  logic signed [pcs_pkg::SUM_W-1:0]  sum;
  logic [pcs_pkg::SUM_W-pcs_pkg::DATA_W:0] top_bits;

  // The product is rounded to nearest with ties toward plus infinity, the
  // coefficient is added, and the sum is clipped to the 32-bit range.
  always_comb begin
    biased   = prod_q + pcs_pkg::PROD_W'(32768);
    rnd      = biased[pcs_pkg::PROD_W-1:16];
    sum      = {rnd[pcs_pkg::RND_W-1], rnd} +
               {{(pcs_pkg::SUM_W-pcs_pkg::DATA_W){coef_i[pcs_pkg::DATA_W-1]}}, coef_i};
    top_bits = sum[pcs_pkg::SUM_W-1:pcs_pkg::DATA_W-1];
    clip     = !((&top_bits) || !(|top_bits));
    if (clip) begin
      acc_d = sum[pcs_pkg::SUM_W-1] ? pcs_pkg::DATA_MIN : pcs_pkg::DATA_MAX;
    end else begin
      acc_d = sum[pcs_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= pcs_pkg::PROD_W'(acc_q) * pcs_pkg::PROD_W'(x_i);
    end
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (ctrl_i.start) begin
      sat_q <= 1'b0;
    end else if (ctrl_i.acc_en && clip) begin
      sat_q <= 1'b1;
    end
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

[rtl/polynomial_coefficient_store_core.sv]
// Channel | Handshake                 | Payload
// input   | in_valid_i / in_ready_o   | action_i, exponent_i, value_i
// output  | out_valid_o / out_ready_i | result_o, degree_o, error_o, saturated_o
//
// Each transaction runs from acceptance through TERMS ring steps to the next
// acceptance; each ring step passes through the multiplier state and then the
// round, add and clip state, and no new transaction is taken before the last one
// has left ST_DONE. Reset clears the coefficients, the state and out_valid_o.
// A waiting result holds the output register while the next transaction runs;
// a stall on the output only holds the end of the following one.
`default_nettype none

module polynomial_coefficient_store_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [pcs_pkg::ACT_W-1:0]         action_i,
  input  wire logic [pcs_pkg::EXP_W-1:0]         exponent_i,
  input  wire logic signed [pcs_pkg::DATA_W-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [pcs_pkg::DATA_W-1:0]      result_o,
  output logic [pcs_pkg::DEG_W-1:0]              degree_o,
  output logic                                   error_o,
  output logic                                   saturated_o
);

  pcs_pkg::state_e state_q, state_d;
  pcs_pkg::horner_ctrl_t hctrl;

  logic                              accept, load_out, shift;
  logic [pcs_pkg::ACT_W-1:0]         act_q;
  logic [pcs_pkg::EXP_W-1:0]         exp_q;
  logic signed [pcs_pkg::DATA_W-1:0] val_q;
  logic [pcs_pkg::IDX_W-1:0]         idx_q;
  logic                              found_q;
  logic [pcs_pkg::IDX_W-1:0]         scan_q;
  logic signed [pcs_pkg::DATA_W-1:0] rd_q;

  logic                              out_valid_q;
  logic signed [pcs_pkg::DATA_W-1:0] result_q;
  logic [pcs_pkg::DEG_W-1:0]         degree_q;
  logic                              error_q, saturated_q;

  logic signed [pcs_pkg::DATA_W-1:0] coef  [pcs_pkg::TERMS];
  logic signed [pcs_pkg::DATA_W-1:0] chain [pcs_pkg::TERMS];
  logic signed [pcs_pkg::DATA_W-1:0] head, wb;
  logic signed [pcs_pkg::DATA_W:0]   add_sum;
  logic signed [pcs_pkg::DATA_W-1:0] acc;
  logic                              sat;
  logic                              valid_exp, hit, is_write;

  assign head      = coef[pcs_pkg::TERMS-1];
  assign valid_exp = (exp_q <= pcs_pkg::EXP_W'(pcs_pkg::TOP_INDEX));
  assign hit       = valid_exp && (pcs_pkg::EXP_W'(idx_q) == exp_q);
  assign is_write  = (act_q == pcs_pkg::ACT_ASSIGN) || (act_q == pcs_pkg::ACT_ADD);

  // The value leaving the top cell re-enters the ring at cell zero, modified when it
  // is the coefficient addressed by an assign or add, or when the table is being cleared.
  always_comb begin
    add_sum = {head[pcs_pkg::DATA_W-1], head} + {val_q[pcs_pkg::DATA_W-1], val_q};
    wb      = head;
    if (act_q == pcs_pkg::ACT_CLEAR) begin
      wb = '0;
    end else if (hit && act_q == pcs_pkg::ACT_ASSIGN) begin
      wb = val_q;
    end else if (hit && act_q == pcs_pkg::ACT_ADD) begin
      if (add_sum[pcs_pkg::DATA_W] != add_sum[pcs_pkg::DATA_W-1]) begin
        wb = add_sum[pcs_pkg::DATA_W] ? pcs_pkg::DATA_MIN : pcs_pkg::DATA_MAX;
      end else begin
        wb = add_sum[pcs_pkg::DATA_W-1:0];
      end
    end
  end

  assign chain[0] = wb;

  for (genvar k = 0; k < pcs_pkg::TERMS; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign chain[k] = coef[k-1];
    end
    pcs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .data_i (chain[k]),
      .data_o (coef[k])
    );
  end

  pcs_horner u_horner (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(hctrl),
    .x_i   (val_q),
    .coef_i(head),
    .acc_o (acc),
    .sat_o (sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    load_out     = 1'b0;
    shift        = 1'b0;
    hctrl.start  = 1'b0;
    hctrl.mul_en = 1'b0;
    hctrl.acc_en = 1'b0;
    case (state_q)
      pcs_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        hctrl.start = in_valid_i;
        if (in_valid_i) begin
          state_d = pcs_pkg::ST_MUL;
        end
      end
      pcs_pkg::ST_MUL: begin
        hctrl.mul_en = 1'b1;
        state_d      = pcs_pkg::ST_ACC;
      end
      pcs_pkg::ST_ACC: begin
        hctrl.acc_en = 1'b1;
        shift        = 1'b1;
        state_d      = (idx_q == '0) ? pcs_pkg::ST_DONE : pcs_pkg::ST_MUL;
      end
      pcs_pkg::ST_DONE: begin
        load_out = !out_valid_q || out_ready_i;
        if (load_out) begin
          state_d = pcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcs_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      exp_q  <= exponent_i;
      val_q  <= value_i;
      idx_q  <= pcs_pkg::IDX_W'(pcs_pkg::TERMS - 1);
      scan_q <= '0;
      rd_q   <= '0;
    end else if (shift) begin
      idx_q <= idx_q - pcs_pkg::IDX_W'(1);
      if (!found_q && wb != '0) begin
        scan_q <= idx_q;
      end
      if (hit && act_q == pcs_pkg::ACT_READ) begin
        rd_q <= head;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (accept) begin
      found_q <= 1'b0;
    end else if (shift && wb != '0) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      degree_q    <= pcs_pkg::DEG_W'(scan_q);
      error_q     <= is_write && !valid_exp;
      saturated_q <= (act_q == pcs_pkg::ACT_EVAL) && sat;
      if (act_q == pcs_pkg::ACT_EVAL) begin
        result_q <= acc;
      end else if (act_q == pcs_pkg::ACT_READ) begin
        result_q <= rd_q;
      end else begin
        result_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign degree_o    = degree_q;
  assign error_o     = error_q;
  assign saturated_o = saturated_q;

endmodule

`default_nettype wire

[rtl/pcs_checker.sv]
`default_nettype none

module pcs_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic [pcs_pkg::ACT_W-1:0]         action_i,
  input wire logic [pcs_pkg::EXP_W-1:0]         exponent_i,
  input wire logic signed [pcs_pkg::DATA_W-1:0] value_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic signed [pcs_pkg::DATA_W-1:0] result_o,
  input wire logic [pcs_pkg::DEG_W-1:0]         degree_o,
  input wire logic                              error_o,
  input wire logic                              saturated_o
);

  // A waiting result must not change before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o) &&
      $stable(degree_o) && $stable(error_o) && $stable(saturated_o))
    else $error("output changed while stalled");

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  // A rejected write reports nothing else.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> result_o == '0 && !saturated_o)
    else $error("error result carries data");

  // A new result only appears after the block has been busy.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without work");

endmodule

bind polynomial_coefficient_store_core pcs_checker u_pcs_checker (.*);

`default_nettype wire

[tb/coef_store_checker.sv]
`timescale 1ns / 1ps

module coef_store_checker
  import pcs_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire logic [ACT_W-1:0]          action_i,
  input  wire logic [EXP_W-1:0]          exponent_i,
  input  wire logic signed [DATA_W-1:0]  value_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire logic signed [DATA_W-1:0]  result_i,
  input  wire logic [DEG_W-1:0]          degree_i,
  input  wire logic                      error_i,
  input  wire logic                      saturated_i,
  output int                             pending_o,
  output int                             fail_count_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic [DEG_W-1:0]         degree;
    logic                     error;
    logic                     saturated;
  } store_reply_t;

  logic signed [DATA_W-1:0] coef_tbl [TERMS];
  int                       cur_degree;
  store_reply_t             replies_due [$];
  int                       mismatches = 0;
  int                       due_count  = 0;

  assign pending_o    = due_count;
  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t checker: %s", $realtime, what);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] clip_q16(input longint v, output bit hit);
    hit = 1'b0;
    if (v > longint'(DATA_MAX)) begin
      hit = 1'b1;
      return DATA_MAX;
    end
    if (v < longint'(DATA_MIN)) begin
      hit = 1'b1;
      return DATA_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic void refresh_degree();
    cur_degree = 0;
    for (int i = 0; i <= TOP_INDEX; i++) begin
      if (coef_tbl[IDX_W'(i)] != '0) begin
        cur_degree = i;
      end
    end
  endfunction

  // Each Horner step rounds the Q32.32 product to nearest, ties upward, and
  // then clips the sum with the next coefficient.
  function automatic logic signed [DATA_W-1:0] horner_at(input logic signed [DATA_W-1:0] x,
                                                        output bit sat);
    logic signed [DATA_W-1:0] acc;
    longint                   prod;
    longint                   sum;
    bit                       hit;
    acc = '0;
    sat = 1'b0;
    for (int i = TOP_INDEX; i >= 0; i--) begin
      prod = longint'(acc) * longint'(x);
      sum  = ((prod + 64'sd32768) >>> 16) + longint'(coef_tbl[IDX_W'(i)]);
      acc  = clip_q16(sum, hit);
      sat  = sat | hit;
    end
    return acc;
  endfunction

  task automatic clear_store();
    for (int i = 0; i < TERMS; i++) begin
      coef_tbl[IDX_W'(i)] = '0;
    end
    cur_degree = 0;
  endtask

  task automatic apply_store_op(input logic [ACT_W-1:0] act, input logic [EXP_W-1:0] expo,
                                input logic signed [DATA_W-1:0] val,
                                output store_reply_t rep);
    bit in_range;
    bit ignored;
    bit sat;
    rep      = '0;
    in_range = (expo <= EXP_W'(TOP_INDEX));
    case (act)
      ACT_ASSIGN, ACT_ADD: begin
        if (!in_range) begin
          rep.error = 1'b1;
        end else begin
          if (act == ACT_ASSIGN) begin
            coef_tbl[expo[IDX_W-1:0]] = val;
          end else begin
            coef_tbl[expo[IDX_W-1:0]] =
              clip_q16(longint'(coef_tbl[expo[IDX_W-1:0]]) + longint'(val), ignored);
          end
          refresh_degree();
        end
      end
      ACT_CLEAR: begin
        clear_store();
      end
      ACT_READ: begin
        if (in_range) begin
          rep.result = coef_tbl[expo[IDX_W-1:0]];
        end
      end
      ACT_EVAL: begin
        rep.result    = horner_at(val, sat);
        rep.saturated = sat;
      end
      default: begin
      end
    endcase
    rep.degree = DEG_W'(cur_degree);
  endtask

  always @(posedge clk_i) begin
    store_reply_t want;
    store_reply_t fresh;
    if (!rst_ni) begin
      clear_store();
      replies_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          report_mismatch("output transaction with no input transaction pending");
        end else begin
          want = replies_due.pop_front();
          if (result_i !== want.result) begin
            report_mismatch($sformatf("result %h, expected %h", result_i, want.result));
          end
          if (degree_i !== want.degree) begin
            report_mismatch($sformatf("degree %0d, expected %0d", degree_i, want.degree));
          end
          if (error_i !== want.error) begin
            report_mismatch($sformatf("error %b, expected %b", error_i, want.error));
          end
          if (saturated_i !== want.saturated) begin
            report_mismatch($sformatf("saturated %b, expected %b", saturated_i,
                                      want.saturated));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_store_op(action_i, exponent_i, value_i, fresh);
        replies_due.push_back(fresh);
      end
    end
    due_count <= replies_due.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import pcs_pkg::*;

  localparam int ACT_LAST  = (1 << ACT_W) - 1;
  localparam int EXP_LAST  = (1 << EXP_W) - 1;
  localparam int OP_CYCLES = 2 * TERMS + 2;
  localparam int PER_PHASE = 325;
  localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_HALF = 32'h0000_8000;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [ACT_W-1:0]         action    = '0;
  logic [EXP_W-1:0]         exponent  = '0;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] result;
  logic [DEG_W-1:0]         degree;
  logic                     error;
  logic                     saturated;
  int                       pending;
  int                       fail_count;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int stall_hold = 0;
  int idle_plan  [4] = '{0, 55, 0, 27};
  int stall_plan [4] = '{0, 0, 55, 27};

  polynomial_coefficient_store_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .exponent_i  (exponent),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .result_o    (result),
    .degree_o    (degree),
    .error_o     (error),
    .saturated_o (saturated)
  );

  coef_store_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .exponent_i   (exponent),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .result_i     (result),
    .degree_i     (degree),
    .error_i      (error),
    .saturated_i  (saturated),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Stalls are drawn at random each cycle; now and then one is held for up to a full transaction.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      if ($urandom_range(15) == 0) begin
        stall_hold = $urandom_range(1, OP_CYCLES);
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_op(input logic [ACT_W-1:0] act, input logic [EXP_W-1:0] expo,
                         input logic [DATA_W-1:0] val);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, OP_CYCLES + 8) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    exponent <= expo;
    value    <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(input bit as_x);
    case ($urandom_range(9))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return '0;
      3, 4: return $urandom();
      default: begin
        if (as_x) begin
          return $urandom_range(0, 32'h0002_8000) - 32'h0001_4000;
        end
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      end
    endcase
  endfunction

  task automatic send_random_op();
    int                 pick;
    logic [ACT_W-1:0]   act;
    logic [EXP_W-1:0]   expo;
    pick = $urandom_range(99);
    if (pick < 25) begin
      act = ACT_ASSIGN;
    end else if (pick < 45) begin
      act = ACT_ADD;
    end else if (pick < 65) begin
      act = ACT_READ;
    end else if (pick < 90) begin
      act = ACT_EVAL;
    end else if (pick < 94) begin
      act = ACT_CLEAR;
    end else begin
      act = ACT_W'($urandom_range(ACT_EVAL + 1, ACT_LAST));
    end
    if ($urandom_range(9) == 0) begin
      expo = EXP_W'($urandom_range(TOP_INDEX + 1, EXP_LAST));
    end else begin
      expo = EXP_W'($urandom_range(TOP_INDEX));
    end
    send_op(act, expo, pick_value(act == ACT_EVAL));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_op(ACT_READ, EXP_W'(0), $urandom());
    send_op(ACT_EVAL, EXP_W'($urandom()), DATA_MAX);
    send_op(ACT_ASSIGN, EXP_W'(0), DATA_MAX);
    send_op(ACT_ASSIGN, EXP_W'(TOP_INDEX), DATA_MIN);
    send_op(ACT_READ, EXP_W'(TOP_INDEX), $urandom());
    send_op(ACT_ADD, EXP_W'(TOP_INDEX), 32'hFFFF_FFFF);
    send_op(ACT_ADD, EXP_W'(0), DATA_MAX);
    send_op(ACT_EVAL, EXP_W'(0), DATA_MAX);
    send_op(ACT_EVAL, EXP_W'(0), DATA_MIN);
    send_op(ACT_ASSIGN, EXP_W'(TOP_INDEX + 1), Q_ONE);
    send_op(ACT_ADD, EXP_W'(EXP_LAST), Q_ONE);
    send_op(ACT_READ, EXP_W'(EXP_LAST), $urandom());
    send_op(ACT_READ, EXP_W'(TOP_INDEX + 1), $urandom());
    send_op(ACT_W'(ACT_EVAL + 1), EXP_W'($urandom()), $urandom());
    send_op(ACT_W'(ACT_LAST), EXP_W'($urandom()), $urandom());
    send_op(ACT_ASSIGN, EXP_W'(5), Q_ONE);
    send_op(ACT_ASSIGN, EXP_W'(TOP_INDEX), '0);
    send_op(ACT_ASSIGN, EXP_W'(5), '0);
    send_op(ACT_CLEAR, EXP_W'($urandom()), $urandom());
    send_op(ACT_EVAL, EXP_W'(0), Q_ONE);
    send_op(ACT_ASSIGN, EXP_W'(1), 32'h0000_0001);
    send_op(ACT_EVAL, EXP_W'(0), Q_HALF);
    send_op(ACT_EVAL, EXP_W'(0), 32'hFFFF_8000);
    send_op(ACT_ASSIGN, EXP_W'(0), 32'hFFFF_0000);
    send_op(ACT_EVAL, EXP_W'(0), 32'hFFFF_0000);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      repeat (PER_PHASE) send_random_op();
      wait_drained();
    end

    stall_pct = 0;
    repeat (OP_CYCLES * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[polynomial_coefficient_store_core.f]
rtl/pcs_pkg.sv
rtl/pcs_cell.sv
rtl/pcs_horner.sv
rtl/polynomial_coefficient_store_core.sv
rtl/pcs_checker.sv
tb/coef_store_checker.sv
tb/tb.sv
